// ===== rtl/core/sld_pkg.sv =====
// Shared types and constants for the start/length/sum deframer.
package sld_pkg;

    localparam logic [7:0] START_BYTE_RST = 8'h68;
    localparam logic       REG_START_BYTE = 1'b0;
    localparam int         LEN_MIN        = 4;
    localparam int         LEN_MARGIN     = 4;
    localparam int         OVR_MARGIN     = 10;
    localparam int         HDR_BYTES      = 4;

    typedef struct packed {
        logic wr;
        logic done;
        logic bus;
    } t_rx_evt;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_EMIT = 3'b100
    } t_emit_state;

endpackage

// ===== rtl/core/sld_rx_if.sv =====
// Receive channel: serial byte with bus flag.
interface sld_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       via_rs485;

    modport source (output valid, output rx_byte, output via_rs485, input ready);
    modport sink   (input valid, input rx_byte, input via_rs485, output ready);
endinterface

// ===== rtl/core/sld_tx_if.sv =====
// Transmit channel: one byte of an accepted frame.
interface sld_tx_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       is_last;
    logic       from_rs485;

    modport source (output valid, output frame_byte, output is_last, output from_rs485,
                    input ready);
    modport sink   (input valid, input frame_byte, input is_last, input from_rs485,
                    output ready);
endinterface

// ===== rtl/core/sld_rx_ctrl.sv =====
// Frame tracker: hunting, position, length check and running checksum.
module sld_rx_ctrl #(
    parameter int BUF_BYTES = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    sld_rx_if.sink                       i_rx,
    input  logic                         i_busy,
    input  logic [7:0]                   i_start_byte,
    output sld_pkg::t_rx_evt             o_evt,
    output logic [$clog2(BUF_BYTES)-1:0] o_wr_addr,
    output logic [7:0]                   o_len
);
    localparam int AW = $clog2(BUF_BYTES);

    logic [AW-1:0] r_pos, n_pos;
    logic [7:0]    r_len, n_len;
    logic [7:0]    r_sum, n_sum;

    logic          fire, hunt_miss, overrun, store, chk, bad_len, stray, complete;
    logic [AW-1:0] pos1;
    logic [8:0]    pos1_x, len_p1;

    assign i_rx.ready = !i_busy;
    assign fire       = i_rx.valid && !i_busy;

    always_comb begin
        hunt_miss = (r_pos == '0) && (i_rx.rx_byte != i_start_byte);
        overrun   = r_pos > AW'(BUF_BYTES - sld_pkg::OVR_MARGIN);
        store     = fire && !hunt_miss && !overrun;
        pos1      = r_pos + AW'(1);
        pos1_x    = 9'(pos1);
        len_p1    = {1'b0, r_len} + 9'd1;
        chk       = pos1 >= AW'(sld_pkg::HDR_BYTES);
        bad_len   = (r_len < 8'(sld_pkg::LEN_MIN))
                 || (r_len > 8'(BUF_BYTES - sld_pkg::LEN_MARGIN));
        stray     = pos1_x > len_p1;
        complete  = pos1_x == len_p1;

        n_pos = r_pos;
        n_len = r_len;
        n_sum = r_sum;
        if (fire && !hunt_miss) begin
            if (overrun) begin
                n_pos = '0;
            end else if (chk && (bad_len || stray || complete)) begin
                n_pos = '0;
            end else begin
                n_pos = pos1;
            end
        end
        if (store) begin
            if (r_pos == '0) begin
                n_sum = '0;
            end else begin
                n_sum = r_sum + i_rx.rx_byte;
            end
            if (r_pos == AW'(1)) begin
                n_len = i_rx.rx_byte;
            end
        end

        o_evt.wr   = store;
        o_evt.done = store && chk && !bad_len && !stray && complete
                  && (r_sum == i_rx.rx_byte);
        o_evt.bus  = i_rx.via_rs485;
    end

    assign o_wr_addr = r_pos;
    assign o_len     = r_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
        r_len <= n_len;
        r_sum <= n_sum;
    end
endmodule

// ===== rtl/core/sld_emit.sv =====
// Frame store and readout sequencer, one stored byte per read/emit pair.
module sld_emit #(
    parameter int BUF_BYTES = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  sld_pkg::t_rx_evt             i_evt,
    input  logic [$clog2(BUF_BYTES)-1:0] i_wr_addr,
    input  logic [7:0]                   i_wr_data,
    input  logic [7:0]                   i_len,
    sld_tx_if.source                     o_tx,
    output logic                         o_busy
);
    localparam int AW = $clog2(BUF_BYTES);

    logic [7:0]           r_mem [BUF_BYTES];
    sld_pkg::t_emit_state r_state, n_state;
    logic [AW-1:0]        r_idx, n_idx;
    logic [7:0]           r_len, n_len;
    logic                 r_bus, n_bus;
    logic [7:0]           r_rdata;
    logic                 last;

    assign last = ({{(8-AW){1'b0}}, r_idx} + 8'd1) == r_len;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_len   = r_len;
        n_bus   = r_bus;
        unique case (r_state)
            sld_pkg::S_IDLE: begin
                if (i_evt.done) begin
                    n_state = sld_pkg::S_READ;
                    n_idx   = '0;
                    n_len   = i_len;
                    n_bus   = i_evt.bus;
                end
            end
            sld_pkg::S_READ: begin
                n_state = sld_pkg::S_EMIT;
            end
            sld_pkg::S_EMIT: begin
                if (o_tx.ready) begin
                    if (last) begin
                        n_state = sld_pkg::S_IDLE;
                    end else begin
                        n_idx   = r_idx + AW'(1);
                        n_state = sld_pkg::S_READ;
                    end
                end
            end
            default: begin
                n_state = sld_pkg::S_IDLE;
            end
        endcase
    end

    assign o_tx.valid      = r_state == sld_pkg::S_EMIT;
    assign o_tx.frame_byte = r_rdata;
    assign o_tx.is_last    = last;
    assign o_tx.from_rs485 = r_bus;
    assign o_busy          = r_state != sld_pkg::S_IDLE;

    always_ff @(posedge i_clk) begin
        if (i_evt.wr) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (r_state == sld_pkg::S_READ) begin
            r_rdata <= r_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sld_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_idx <= n_idx;
        r_len <= n_len;
        r_bus <= n_bus;
    end
endmodule

// ===== rtl/core/start_length_sum_deframer_core.sv =====
// Top level of the start/length/sum frame receiver.
//
//  channel   dir  handshake      word
//  i_rx      in   valid/ready    rx_byte[7:0], via_rs485
//  o_tx      out  valid/ready    frame_byte[7:0], is_last, from_rs485
//  apb       in   psel/penable   start_byte at 0x0
//
// A byte that does not complete a good frame leaves i_rx.ready high.
// A byte that completes a good frame keeps i_rx.ready low until its last word is taken:
// each emitted word needs a frame-store read state then an emit state, which output stalls hold.
// Reset clears position, sequencer and start_byte (0x68); frame store is not cleared.
// o_tx stalls hold the word; i_rx is not ready until the last word is taken.
module start_length_sum_deframer_core #(
    parameter int BUF_BYTES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sld_rx_if.sink      i_rx,
    sld_tx_if.source    o_tx,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int AW = $clog2(BUF_BYTES);

    logic [7:0]       r_start_byte;
    sld_pkg::t_rx_evt evt;
    logic [AW-1:0]    wr_addr;
    logic [7:0]       len;
    logic             busy;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == sld_pkg::REG_START_BYTE);
    assign prdata = (paddr[2] == sld_pkg::REG_START_BYTE) ? {24'd0, r_start_byte} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= sld_pkg::START_BYTE_RST;
        end else if (cfg_wr) begin
            r_start_byte <= pwdata[7:0];
        end
    end

    sld_rx_ctrl #(
        .BUF_BYTES (BUF_BYTES)
    ) u_rx_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rx         (i_rx),
        .i_busy       (busy),
        .i_start_byte (r_start_byte),
        .o_evt        (evt),
        .o_wr_addr    (wr_addr),
        .o_len        (len)
    );

    sld_emit #(
        .BUF_BYTES (BUF_BYTES)
    ) u_emit (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_evt     (evt),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_rx.rx_byte),
        .i_len     (len),
        .o_tx      (o_tx),
        .o_busy    (busy)
    );

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_tx.valid && i_rx.ready))
        else $error("input ready while a word is pending");

    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tx.valid && o_tx.ready && o_tx.is_last) |=> i_rx.ready)
        else $error("not ready after last word");

    a_done_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (evt.done && i_rx.valid && i_rx.ready) |=> (busy && !o_tx.valid))
        else $error("frame done did not start readout");

    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_wr |=> (r_start_byte == $past(pwdata[7:0])))
        else $error("start byte write lost");
endmodule

// ===== tb/tb_start_length_sum_deframer_core.sv =====
// Self-checking testbench for the start/length/sum frame receiver core.
module tb_start_length_sum_deframer_core;

    localparam int         BUF_BYTES   = 64;
    localparam int         STALL_LIMIT = 5000;
    localparam logic [2:0] START_ADDR  = {sld_pkg::REG_START_BYTE, 2'b00};
    localparam logic [2:0] SPARE_ADDR  = 3'd4;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       bus;
    } t_frame_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        tx_ready = 1'b0;

    sld_rx_if rx_bus ();
    sld_tx_if tx_bus ();

    assign tx_bus.ready = tx_ready;

    start_length_sum_deframer_core #(
        .BUF_BYTES (BUF_BYTES)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_bus),
        .o_tx    (tx_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // deframer model state
    logic [7:0]  frame_buf [BUF_BYTES];
    logic [6:0]  wr_pos;
    logic [7:0]  cur_start;
    t_frame_word pending_words[$];

    int err_count     = 0;
    int sent_count    = 0;
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int stall_cycles  = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void deframe_byte(input logic [7:0] b, input logic bus);
        int unsigned pos;
        int unsigned len;
        logic [7:0]  sum;
        t_frame_word w;
        pos = wr_pos;
        if (pos == 0 && b != cur_start) return;
        if (pos > BUF_BYTES - sld_pkg::OVR_MARGIN) begin
            wr_pos = '0;
            return;
        end
        frame_buf[pos] = b;
        pos++;
        wr_pos = 7'(pos);
        if (pos < sld_pkg::HDR_BYTES) return;
        len = frame_buf[1];
        if (len < sld_pkg::LEN_MIN || len > BUF_BYTES - sld_pkg::LEN_MARGIN
            || pos > len + 1) begin
            wr_pos = '0;
            return;
        end
        if (pos != len + 1) return;
        wr_pos = '0;
        sum = '0;
        for (int i = 1; i < len; i++) sum += frame_buf[i];
        if (sum != frame_buf[len]) return;
        for (int i = 0; i < len; i++) begin
            w.data = frame_buf[i];
            w.last = (i + 1 == len);
            w.bus  = bus;
            pending_words.push_back(w);
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && rx_bus.valid && rx_bus.ready) deframe_byte(rx_bus.rx_byte, rx_bus.via_rs485);
    end

    always @(posedge i_clk) begin : check_words
        t_frame_word w;
        if (i_rst_n && tx_bus.valid && tx_bus.ready) begin
            if (pending_words.size() == 0) begin
                $display("%0t: unexpected word expected none got %h last %b bus %b", $time,
                         tx_bus.frame_byte, tx_bus.is_last, tx_bus.from_rs485);
                err_count++;
            end else begin
                w = pending_words.pop_front();
                if (tx_bus.frame_byte !== w.data) begin
                    $display("%0t: frame_byte expected %h got %h", $time, w.data,
                             tx_bus.frame_byte);
                    err_count++;
                end
                if (tx_bus.is_last !== w.last) begin
                    $display("%0t: is_last expected %b got %b", $time, w.last, tx_bus.is_last);
                    err_count++;
                end
                if (tx_bus.from_rs485 !== w.bus) begin
                    $display("%0t: from_rs485 expected %b got %b", $time, w.bus,
                             tx_bus.from_rs485);
                    err_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        tx_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    always @(posedge i_clk) begin
        if ((rx_bus.valid && rx_bus.ready) || (tx_bus.valid && tx_bus.ready) ||
            (psel && penable) || !i_rst_n) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_word(input logic [7:0] b, input logic bus);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            rx_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        rx_bus.valid     <= 1'b1;
        rx_bus.rx_byte   <= b;
        rx_bus.via_rs485 <= bus;
        do @(posedge i_clk); while (!(rx_bus.valid && rx_bus.ready));
        sent_count++;
    endtask

    // start, length, body, checksum; max_bytes cuts the frame short
    task automatic send_frame(input logic [7:0] sb, input int len, input bit corrupt,
                              input int max_bytes);
        logic [7:0] body[$];
        logic [7:0] sum;
        sum = 8'(len);
        body.push_back(sb);
        body.push_back(8'(len));
        for (int i = 2; i < len; i++) begin
            body.push_back(8'($urandom));
            sum += body[i];
        end
        if (corrupt) sum ^= 8'($urandom_range(1, 255));
        body.push_back(sum);
        while (body.size() < sld_pkg::HDR_BYTES + 2) body.push_back(8'($urandom));
        for (int i = 0; i < body.size() && i < max_bytes; i++)
            send_word(body[i], 1'($urandom_range(0, 1)));
    endtask

    // sender holds off until every expected word is out
    task automatic settle();
        rx_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr == START_ADDR) cur_start = data[7:0];
    endtask

    task automatic check_start_reg();
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= START_ADDR;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[7:0] !== cur_start) begin
            $display("%0t: start_byte read expected %h got %h", $time, cur_start, prdata[7:0]);
            err_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_start(input logic [7:0] value);
        settle();
        apb_write(START_ADDR, {24'($urandom), value});
        check_start_reg();
    endtask

    task automatic test_hunt();
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b1);
        send_word(8'h67, 1'b0);
    endtask

    task automatic test_min_frames();
        send_frame(cur_start, sld_pkg::LEN_MIN, 1'b0, 99);
        send_frame(cur_start, sld_pkg::LEN_MIN, 1'b1, 99);
    endtask

    task automatic test_bad_length();
        send_frame(cur_start, sld_pkg::LEN_MIN - 1, 1'b0, sld_pkg::HDR_BYTES);
        send_frame(cur_start, BUF_BYTES - sld_pkg::LEN_MARGIN + 1, 1'b0,
                   sld_pkg::HDR_BYTES + 1);
    endtask

    task automatic test_start_reg();
        settle();
        check_start_reg();
        apb_write(SPARE_ADDR, 32'h0000_00A5);
        check_start_reg();
        set_start(8'h00);
        send_frame(cur_start, sld_pkg::LEN_MIN, 1'b0, 99);
        set_start(8'hFF);
        send_frame(cur_start, sld_pkg::LEN_MIN, 1'b0, 99);
        set_start(sld_pkg::START_BYTE_RST);
    endtask

    task automatic test_long_frames();
        send_frame(cur_start, BUF_BYTES - sld_pkg::OVR_MARGIN, 1'b0, 99);
        send_frame(cur_start, BUF_BYTES - sld_pkg::LEN_MARGIN, 1'b0, 99);
    endtask

    task automatic run_traffic(input int n_bytes);
        int stop_at;
        int kind;
        stop_at = sent_count + n_bytes;
        while (sent_count < stop_at) begin
            kind = $urandom_range(0, 99);
            if (kind < 62) begin
                send_frame(cur_start, $urandom_range(sld_pkg::LEN_MIN, 12), 1'b0, 99);
            end else if (kind < 66) begin
                send_frame(cur_start, $urandom_range(13, BUF_BYTES - sld_pkg::OVR_MARGIN),
                           1'b0, 99);
            end else if (kind < 76) begin
                send_frame(cur_start, $urandom_range(sld_pkg::LEN_MIN, 12), 1'b1, 99);
            end else if (kind < 84) begin
                if ($urandom_range(0, 1))
                    send_frame(cur_start, $urandom_range(0, sld_pkg::LEN_MIN - 1), 1'b0,
                               $urandom_range(sld_pkg::HDR_BYTES, sld_pkg::HDR_BYTES + 2));
                else
                    send_frame(cur_start,
                               $urandom_range(BUF_BYTES - sld_pkg::LEN_MARGIN + 1, 255), 1'b0,
                               $urandom_range(sld_pkg::HDR_BYTES, sld_pkg::HDR_BYTES + 2));
            end else if (kind < 86) begin
                send_frame(cur_start, $urandom_range(BUF_BYTES - sld_pkg::OVR_MARGIN + 1,
                           BUF_BYTES - sld_pkg::LEN_MARGIN), 1'b0, 99);
            end else begin
                repeat ($urandom_range(1, 4))
                    send_word(8'($urandom), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    initial begin
        i_rst_n          <= 1'b0;
        rx_bus.valid     <= 1'b0;
        rx_bus.rx_byte   <= 8'h00;
        rx_bus.via_rs485 <= 1'b0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        wr_pos    = '0;
        cur_start = sld_pkg::START_BYTE_RST;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        src_idle_pct  = 37;
        sink_idle_pct = 87;
        test_hunt();
        test_min_frames();
        test_bad_length();
        test_start_reg();
        test_long_frames();
        run_traffic(100);

        set_start(8'($urandom_range(0, 255)));
        src_idle_pct  = 87;
        sink_idle_pct = 37;
        run_traffic(100);

        set_start(8'($urandom_range(0, 255)));
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        run_traffic(100);

        settle();
        repeat (120) @(posedge i_clk);
        if (err_count == 0 && pending_words.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
